### rtl/vab_pkg.sv
// ----------------------------------------------------------------------------
// vab_pkg
// Shared types and constants of the vector accumulation buffer.
// ----------------------------------------------------------------------------
package vab_pkg;

  localparam int unsigned FieldW      = 32;
  localparam int unsigned FieldLanes  = 4;
  localparam int unsigned TdataW      = FieldW * FieldLanes;
  localparam int unsigned CfgW        = 10;
  localparam logic [CfgW-1:0] CfgReset = 10'd512;

  typedef enum logic [1:0] {
    FUNC_ACC    = 2'd0,
    FUNC_SET    = 2'd1,
    FUNC_SET_WB = 2'd2,
    FUNC_ACC_WB = 2'd3
  } func_e;

endpackage

### rtl/vector_accumulation_buffer_unit.sv
// ----------------------------------------------------------------------------
// vector_accumulation_buffer_unit
// Circular buffer of vector accumulators with set, accumulate and write-back.
// ----------------------------------------------------------------------------
// Each word taken on the slave stream carries an operation in tuser and one
// vector of lanes in tdata. The word either overwrites or is added to the
// buffer entry under a circular pointer, which then advances and wraps after
// the configured number of entries. The write-back operations send the new
// entry value out on the master stream; the other operations send nothing.
// A new word is taken every cycle while the input stage can advance. Each
// result is registered: the memory read is registered together with the word, and
// the add feeds the output register. A bypass on the last written entry
// keeps the read-modify-write exact at full rate, even with a single entry.
// Reset clears the pointer and sets the size to 512; the memory reads as
// zero until written, tracked by a fill count since entries fill in order.
// When the master side stalls, the output register holds its word and the stage
// behind it stalls only if it also has a result to send. The user must write the
// size register through cfg_we_i only while the stream is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module vector_accumulation_buffer_unit #(
  parameter int unsigned MEMORY_DEPTH  = 512,
  parameter int unsigned VECTOR_LANES  = 4,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [vab_pkg::CfgW-1:0]     cfg_wdata_i,    // entries_in_use
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [vab_pkg::TdataW-1:0]   s_axis_tdata_i, // value_0..value_3
  input  logic [1:0]                   s_axis_tuser_i, // func
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [vab_pkg::TdataW-1:0]   m_axis_tdata_o  // sum_0..sum_3
);

  localparam int unsigned AddrW  = $clog2(MEMORY_DEPTH);
  localparam int unsigned SizeW  = $clog2(MEMORY_DEPTH + 1);
  localparam int unsigned CmpW   = ((SizeW > vab_pkg::CfgW) ? SizeW : vab_pkg::CfgW) + 1;
  localparam int unsigned WordW  = VECTOR_LANES * ELEMENT_WIDTH;
  localparam int unsigned FW     = vab_pkg::FieldW;

  logic [vab_pkg::CfgW-1:0] cfg_q;
  logic [CmpW-1:0]          size_eff;
  logic [AddrW-1:0]         ptr_q, ptr_d;
  logic [CmpW-1:0]          ptr_inc;
  logic                     in_acc;

  logic                     s1_valid_q;
  logic [1:0]               s1_func_q;
  logic [vab_pkg::TdataW-1:0] s1_val_q;
  logic [AddrW-1:0]         s1_addr_q;
  logic [WordW-1:0]         rdata_q;
  logic                     s1_set, s1_emit, s1_adv;

  logic                     lw_valid_q;
  logic [AddrW-1:0]         lw_addr_q;
  logic [WordW-1:0]         lw_data_q;
  logic [SizeW-1:0]         fill_q;
  logic [SizeW-1:0]         addr_inc;

  logic [WordW-1:0]         old_word, new_word;
  logic [vab_pkg::TdataW-1:0] sum_vec;
  logic                     out_valid_q;
  logic [vab_pkg::TdataW-1:0] out_data_q;

  logic [WordW-1:0]         mem [MEMORY_DEPTH];

  always_comb begin
    if (cfg_q == '0 || CmpW'(cfg_q) > CmpW'(MEMORY_DEPTH)) begin
      size_eff = CmpW'(MEMORY_DEPTH);
    end else begin
      size_eff = CmpW'(cfg_q);
    end
  end

  assign ptr_inc = CmpW'(ptr_q) + CmpW'(1);
  assign ptr_d   = (ptr_inc >= size_eff) ? '0 : AddrW'(ptr_inc);

  assign s1_set  = (s1_func_q == vab_pkg::FUNC_SET) || (s1_func_q == vab_pkg::FUNC_SET_WB);
  assign s1_emit = (s1_func_q == vab_pkg::FUNC_SET_WB) || (s1_func_q == vab_pkg::FUNC_ACC_WB);
  assign s1_adv  = s1_valid_q && (!s1_emit || !out_valid_q || m_axis_tready_i);

  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    if (lw_valid_q && lw_addr_q == s1_addr_q) begin
      old_word = lw_data_q;
    end else if (SizeW'(s1_addr_q) < fill_q) begin
      old_word = rdata_q;
    end else begin
      old_word = '0;
    end
  end

  for (genvar l = 0; l < vab_pkg::FieldLanes; l++) begin : g_lane
    if (l < VECTOR_LANES) begin : g_used
      logic signed [FW-1:0]        in_f;
      logic [ELEMENT_WIDTH-1:0]    in_e, old_e, new_e;
      assign in_f  = s1_val_q[l*FW +: FW];
      assign in_e  = ELEMENT_WIDTH'(in_f);
      assign old_e = old_word[l*ELEMENT_WIDTH +: ELEMENT_WIDTH];
      assign new_e = s1_set ? in_e : old_e + in_e;
      assign new_word[l*ELEMENT_WIDTH +: ELEMENT_WIDTH] = new_e;
      assign sum_vec[l*FW +: FW] = FW'(new_e);
    end else begin : g_unused
      assign sum_vec[l*FW +: FW] = '0;
    end
  end

  assign addr_inc = SizeW'(s1_addr_q) + SizeW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= vab_pkg::CfgReset;
      ptr_q       <= '0;
      s1_valid_q  <= 1'b0;
      lw_valid_q  <= 1'b0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        ptr_q <= ptr_d;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        lw_valid_q <= 1'b1;
        if (addr_inc > fill_q) begin
          fill_q <= addr_inc;
        end
      end
      if (s1_adv && s1_emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q <= s_axis_tuser_i;
      s1_val_q  <= s_axis_tdata_i;
      s1_addr_q <= ptr_q;
    end
    if (s1_adv) begin
      lw_addr_q <= s1_addr_q;
      lw_data_q <= new_word;
    end
    if (s1_adv && s1_emit) begin
      out_data_q <= sum_vec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rdata_q <= mem[ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mem[s1_addr_q] <= new_word;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
